// File: rtl/core/tpi_pkg.sv
// Shared types and constants for the three-plane intersection unit.
package tpi_pkg;

	localparam int D_W  = 49;
	localparam int R_W  = 49;
	localparam int Q_W  = 33;
	localparam int N_W  = 81;
	localparam int NUM_W = 67;
	localparam int MAG_W = 64;
	localparam int DEN_W = 51;
	localparam int DMAG_W = 48;
	localparam logic [15:0] MIN_DET_RST = 16'd1024;

	typedef struct packed {
		logic [R_W-1:0] rem;
		logic [Q_W-1:0] low;
		logic [Q_W-1:0] quo;
		logic           ovf;
		logic           neg;
	} lane_t;

	typedef struct packed {
		logic           vld;
		logic           deg;
		logic [D_W-1:0] dv;
		lane_t [2:0]    lane;
	} slot_t;

	// a*b - c*e
	function automatic logic signed [32:0] xmul(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic signed [15:0] c,
			input logic signed [15:0] e);
		logic signed [31:0] p0;
		logic signed [31:0] p1;
		p0 = a * b;
		p1 = c * e;
		return $signed({p0[31], p0}) - $signed({p1[31], p1});
	endfunction

endpackage

// File: rtl/core/tpi_cell.sv
// One restoring-division cell: a quotient bit for each coordinate lane.
module tpi_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  tpi_pkg::slot_t din,
	output tpi_pkg::slot_t dout
);
	import tpi_pkg::*;

	slot_t nxt;
	slot_t slot_q;
	logic  vld_q;
	logic [R_W:0] t;
	logic         ge;

	always_comb begin
		nxt = din;
		t = '0;
		ge = 1'b0;
		for (int k = 0; k < 3; k++) begin
			t = {din.lane[k].rem, din.lane[k].low[Q_W-1]};
			ge = (t >= {1'b0, din.dv});
			nxt.lane[k].rem = ge ? R_W'(t - {1'b0, din.dv}) : t[R_W-1:0];
			nxt.lane[k].low = {din.lane[k].low[Q_W-2:0], 1'b0};
			nxt.lane[k].quo = {din.lane[k].quo[Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= nxt;
	end

	always_comb begin
		dout = slot_q;
		dout.vld = vld_q;
	end

endmodule

// File: rtl/core/tpi_front.sv
// Front pipeline: cross products, determinant, numerators, dividend setup.
module tpi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic        [15:0] min_det,
	input  logic signed [15:0] n1x, n1y, n1z,
	input  logic signed [15:0] n2x, n2y, n2z,
	input  logic signed [15:0] n3x, n3y, n3z,
	input  logic signed [31:0] d1, d2, d3,
	output tpi_pkg::slot_t     dout
);
	import tpi_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [32:0] c23_s1 [3];
	logic signed [32:0] b_s1 [3];
	logic signed [32:0] c_s1 [3];
	logic signed [15:0] n1_s1 [3];
	logic signed [31:0] d1_s1, d2_s1, d3_s1;

	logic signed [48:0] dp_s2 [3];
	logic signed [64:0] p1_s2 [3];
	logic signed [64:0] p2_s2 [3];
	logic signed [64:0] p3_s2 [3];

	logic signed [DEN_W-1:0] den_s3;
	logic signed [NUM_W-1:0] num_s3 [3];

	logic [MAG_W-1:0]  mag_s4 [3];
	logic [2:0]        neg_s4;
	logic [DMAG_W-1:0] dmag_s4;
	logic              deg_s4;

	logic [N_W-1:0]  nn_s5 [3];
	logic [2:0]      neg_s5;
	logic [D_W-1:0]  dv_s5;
	logic            deg_s5;

	slot_t slot_s6;

	logic [DEN_W-1:0] den_abs;
	logic [NUM_W-1:0] num_abs [3];

	always_comb begin
		den_abs = den_s3[DEN_W-1] ? DEN_W'(-den_s3) : DEN_W'(den_s3);
		for (int k = 0; k < 3; k++) begin
			num_abs[k] = num_s3[k][NUM_W-1] ? NUM_W'(-num_s3[k]) : NUM_W'(num_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		c23_s1[0] <= xmul(n2y, n3z, n2z, n3y);
		c23_s1[1] <= xmul(n2z, n3x, n2x, n3z);
		c23_s1[2] <= xmul(n2x, n3y, n2y, n3x);
		b_s1[0]   <= xmul(n1y, n3z, n1z, n3y);
		b_s1[1]   <= xmul(n1z, n3x, n1x, n3z);
		b_s1[2]   <= xmul(n1x, n3y, n1y, n3x);
		c_s1[0]   <= xmul(n2y, n1z, n2z, n1y);
		c_s1[1]   <= xmul(n2z, n1x, n2x, n1z);
		c_s1[2]   <= xmul(n2x, n1y, n2y, n1x);
		n1_s1[0]  <= n1x;
		n1_s1[1]  <= n1y;
		n1_s1[2]  <= n1z;
		d1_s1     <= d1;
		d2_s1     <= d2;
		d3_s1     <= d3;

		for (int k = 0; k < 3; k++) begin
			dp_s2[k] <= n1_s1[k] * c23_s1[k];
			p1_s2[k] <= d1_s1 * c23_s1[k];
			p2_s2[k] <= d2_s1 * b_s1[k];
			p3_s2[k] <= d3_s1 * c_s1[k];
		end

		// first term uses n3 x n2 = -(n2 x n3)
		den_s3 <= DEN_W'(dp_s2[0]) + DEN_W'(dp_s2[1]) + DEN_W'(dp_s2[2]);
		for (int k = 0; k < 3; k++) begin
			num_s3[k] <= NUM_W'(p2_s2[k]) + NUM_W'(p3_s2[k]) - NUM_W'(p1_s2[k]);
		end

		dmag_s4 <= den_abs[DMAG_W-1:0];
		deg_s4  <= (den_s3 == '0) ||
			(den_abs[DMAG_W-1:0] < DMAG_W'({min_det, 15'b0}));
		for (int k = 0; k < 3; k++) begin
			mag_s4[k] <= num_abs[k][MAG_W-1:0];
			neg_s4[k] <= num_s3[k][NUM_W-1] ^ den_s3[DEN_W-1];
		end

		for (int k = 0; k < 3; k++) begin
			nn_s5[k] <= {1'b0, mag_s4[k], 16'b0} + N_W'(dmag_s4);
		end
		neg_s5 <= neg_s4;
		dv_s5  <= {dmag_s4, 1'b0};
		deg_s5 <= deg_s4;

		slot_s6.vld <= vld_s5;
		slot_s6.deg <= deg_s5;
		slot_s6.dv  <= dv_s5;
		for (int k = 0; k < 3; k++) begin
			slot_s6.lane[k].ovf <= ({1'b0, nn_s5[k][N_W-1:Q_W]} >= dv_s5);
			slot_s6.lane[k].rem <= R_W'(nn_s5[k][N_W-1:Q_W]);
			slot_s6.lane[k].low <= nn_s5[k][Q_W-1:0];
			slot_s6.lane[k].quo <= '0;
			slot_s6.lane[k].neg <= neg_s5[k];
		end
	end

	always_comb begin
		dout = slot_s6;
		dout.vld = vld_s6;
	end

endmodule

// File: rtl/core/three_plane_intersection_unit.sv
// Top level: point where three planes meet, pipelined with a divider cell chain.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | start (busy always low) | first/second/third normal_x/y/z, offset
//  out     | done (one-cycle strobe) | point_x/y/z, point_valid, saturated
//  cfg     | cfg_valid / cfg_ready   | cfg_data -> min_determinant
//
// One word accepted per cycle; done rises once the word has passed all
// 40 register stages: six front, 33 divider cells, one output register.
// arst_n loads min_determinant with 1024 and clears done and the stage valids.
// No stalls: busy stays low and done cannot be held off.
module three_plane_intersection_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [15:0] cfg_data,
	input  logic signed [15:0] first_normal_x,
	input  logic signed [15:0] first_normal_y,
	input  logic signed [15:0] first_normal_z,
	input  logic signed [31:0] first_offset,
	input  logic signed [15:0] second_normal_x,
	input  logic signed [15:0] second_normal_y,
	input  logic signed [15:0] second_normal_z,
	input  logic signed [31:0] second_offset,
	input  logic signed [15:0] third_normal_x,
	input  logic signed [15:0] third_normal_y,
	input  logic signed [15:0] third_normal_z,
	input  logic signed [31:0] third_offset,
	output logic               done,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic               point_valid,
	output logic               saturated
);
	import tpi_pkg::*;

	logic [15:0] min_det_q;
	slot_t       chain [Q_W+1];
	slot_t       tail;
	logic [31:0] val [3];
	logic [2:0]  sat;
	logic        done_q;
	logic [31:0] px_q, py_q, pz_q;
	logic        pv_q, sat_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= MIN_DET_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_det_q <= cfg_data;
		end
	end

	tpi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy),
		.min_det(min_det_q),
		.n1x    (first_normal_x),
		.n1y    (first_normal_y),
		.n1z    (first_normal_z),
		.n2x    (second_normal_x),
		.n2y    (second_normal_y),
		.n2z    (second_normal_z),
		.n3x    (third_normal_x),
		.n3y    (third_normal_y),
		.n3z    (third_normal_z),
		.d1     (first_offset),
		.d2     (second_offset),
		.d3     (third_offset),
		.dout   (chain[0])
	);

	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		tpi_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (chain[i]),
			.dout  (chain[i+1])
		);
	end

	assign tail = chain[Q_W];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (tail.lane[k].neg) begin
				sat[k] = tail.lane[k].ovf || (tail.lane[k].quo > 33'h080000000);
				val[k] = sat[k] ? 32'h80000000 : (~tail.lane[k].quo[31:0] + 32'd1);
			end else begin
				sat[k] = tail.lane[k].ovf || (tail.lane[k].quo > 33'h07FFFFFFF);
				val[k] = sat[k] ? 32'h7FFFFFFF : tail.lane[k].quo[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.deg) begin
			px_q  <= '0;
			py_q  <= '0;
			pz_q  <= '0;
			pv_q  <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			px_q  <= val[0];
			py_q  <= val[1];
			pz_q  <= val[2];
			pv_q  <= 1'b1;
			sat_q <= |sat;
		end
	end

	assign done        = done_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_z     = pz_q;
	assign point_valid = pv_q;
	assign saturated   = sat_q;

endmodule

// File: tb/sv/tpi_checker.sv
// Checker for the three-plane intersection unit: predicts each point and compares results.
module tpi_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic        [15:0] cfg_data,
	input  logic signed [15:0] first_normal_x,
	input  logic signed [15:0] first_normal_y,
	input  logic signed [15:0] first_normal_z,
	input  logic signed [31:0] first_offset,
	input  logic signed [15:0] second_normal_x,
	input  logic signed [15:0] second_normal_y,
	input  logic signed [15:0] second_normal_z,
	input  logic signed [31:0] second_offset,
	input  logic signed [15:0] third_normal_x,
	input  logic signed [15:0] third_normal_y,
	input  logic signed [15:0] third_normal_z,
	input  logic signed [31:0] third_offset,
	input  logic               done,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               point_valid,
	input  logic               saturated,
	output int                 failures,
	output int                 points_pending
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               valid;
		logic               sat;
	} point_t;

	point_t      expected_points[$];
	logic [15:0] min_det;
	int          mismatches;

	function automatic void cross3(input longint u[3], input longint v[3], output longint r[3]);
		r[0] = u[1] * v[2] - u[2] * v[1];
		r[1] = u[2] * v[0] - u[0] * v[2];
		r[2] = u[0] * v[1] - u[1] * v[0];
	endfunction

	// rounded |num|*2^15/|den|, ties away from zero, clamped to Q16.16
	function automatic logic [31:0] scale_coord(input logic signed [127:0] num,
			input longint den, inout logic sat);
		logic               neg;
		logic        [127:0] mag;
		logic        [127:0] dm;
		logic        [127:0] q;
		neg = num[127] ^ (den < 0);
		mag = num[127] ? -num : num;
		dm  = (den < 0) ? 128'(-den) : 128'(den);
		q   = ((mag << 16) + dm) / (dm << 1);
		if (neg) begin
			if (q > 128'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return 32'(-q);
		end
		if (q > 128'h7FFF_FFFF) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return 32'(q);
	endfunction

	function automatic point_t solve_planes(input longint n1[3], input longint n2[3],
			input longint n3[3], input longint d1, input longint d2, input longint d3,
			input logic [15:0] thr);
		point_t                 p;
		longint                 c23[3];
		longint                 a[3];
		longint                 b[3];
		longint                 c[3];
		longint                 den;
		longint                 dmag;
		logic signed [127:0]    num;
		logic                   sat;
		logic          [31:0]   r[3];
		p = '0;
		cross3(n2, n3, c23);
		den  = n1[0] * c23[0] + n1[1] * c23[1] + n1[2] * c23[2];
		dmag = den < 0 ? -den : den;
		if (den == 0 || dmag < (longint'(thr) <<< 15))
			return p;
		cross3(n3, n2, a);
		cross3(n1, n3, b);
		cross3(n2, n1, c);
		sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			num = 128'(signed'(d1 * a[k])) + 128'(signed'(d2 * b[k]))
				+ 128'(signed'(d3 * c[k]));
			r[k] = scale_coord(num, den, sat);
		end
		p.x = r[0];
		p.y = r[1];
		p.z = r[2];
		p.valid = 1'b1;
		p.sat = sat;
		return p;
	endfunction

	assign points_pending = expected_points.size();

	always @(posedge clk or negedge arst_n) begin
		longint n1[3];
		longint n2[3];
		longint n3[3];
		point_t got;
		point_t want;
		point_t pred;
		if (!arst_n) begin
			min_det <= 16'd1024;
			expected_points.delete();
			failures = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				min_det <= cfg_data;
			if (start && !busy) begin
				n1 = '{first_normal_x, first_normal_y, first_normal_z};
				n2 = '{second_normal_x, second_normal_y, second_normal_z};
				n3 = '{third_normal_x, third_normal_y, third_normal_z};
				pred = solve_planes(n1, n2, n3, first_offset,
					second_offset, third_offset, min_det);
				expected_points = {expected_points, pred};
			end
			if (done) begin
				got = '{point_x, point_y, point_z, point_valid, saturated};
				if (expected_points.size() == 0) begin
					failures++;
					if (mismatches++ < 10)
						$display("unexpected point word: %p", got);
				end else begin
					want = expected_points.pop_front();
					if (got !== want) begin
						failures++;
						if (mismatches++ < 10)
							$display("point mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

endmodule

// File: tb/sv/tb_three_plane_intersection_unit.sv
// Testbench top for the three-plane intersection unit: stimulus, watchdog and verdict.
module tb_three_plane_intersection_unit;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LATENCY = 45;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               cfg_valid;
	logic               cfg_ready;
	logic        [15:0] cfg_data;
	logic signed [15:0] nrm[3][3];
	logic signed [31:0] ofs[3];
	logic               done;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic               point_valid;
	logic               saturated;
	int                 failures;
	int                 points_pending;
	int                 idle_cycles;

	three_plane_intersection_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.first_normal_x(nrm[0][0]), .first_normal_y(nrm[0][1]),
		.first_normal_z(nrm[0][2]), .first_offset(ofs[0]),
		.second_normal_x(nrm[1][0]), .second_normal_y(nrm[1][1]),
		.second_normal_z(nrm[1][2]), .second_offset(ofs[1]),
		.third_normal_x(nrm[2][0]), .third_normal_y(nrm[2][1]),
		.third_normal_z(nrm[2][2]), .third_offset(ofs[2]),
		.done(done), .point_x(point_x), .point_y(point_y), .point_z(point_z),
		.point_valid(point_valid), .saturated(saturated)
	);

	tpi_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.first_normal_x(nrm[0][0]), .first_normal_y(nrm[0][1]),
		.first_normal_z(nrm[0][2]), .first_offset(ofs[0]),
		.second_normal_x(nrm[1][0]), .second_normal_y(nrm[1][1]),
		.second_normal_z(nrm[1][2]), .second_offset(ofs[1]),
		.third_normal_x(nrm[2][0]), .third_normal_y(nrm[2][1]),
		.third_normal_z(nrm[2][2]), .third_offset(ofs[2]),
		.done(done), .point_x(point_x), .point_y(point_y), .point_z(point_z),
		.point_valid(point_valid), .saturated(saturated),
		.failures(failures), .points_pending(points_pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("three_plane_intersection_unit regression: fail");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'(signed'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_offset();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	// drives one plane triple and waits until it is accepted
	task automatic send_triple(input logic [15:0] n[9], input logic [31:0] d[3]);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g > 0) begin
			start = 1'b0;
			repeat (g) @(negedge clk);
		end
		for (int i = 0; i < 9; i++)
			nrm[i / 3][i % 3] = n[i];
		for (int i = 0; i < 3; i++)
			ofs[i] = d[i];
		start = 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_random();
		logic [15:0] n[9];
		logic [31:0] d[3];
		int          kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			n[i] = rand_comp();
		for (int i = 0; i < 3; i++)
			d[i] = rand_offset();
		if (kind == 0) begin
			// parallel planes
			n[3] = n[0]; n[4] = n[1]; n[5] = n[2];
		end else if (kind < 3) begin
			// diagonal normals, small determinant around the threshold
			n = '{16'($urandom_range(1, 32767)), 0, 0,
				0, 16'($urandom_range(0, 400)), 0,
				0, 0, 16'($urandom_range(0, 400))};
			if ($urandom_range(0, 1)) n[0] = -n[0];
		end
		send_triple(n, d);
	endtask

	task automatic set_min_det(input logic [15:0] v);
		@(negedge clk);
		start = 1'b0;
		wait (points_pending == 0);
		repeat (LATENCY) @(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] thr, input int count);
		logic [15:0] n[9];
		logic [31:0] d[3];
		d = '{32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF};
		if (thr <= 16'd32767) begin
			// determinant exactly on and just below the threshold
			n = '{16'h8000, 0, 0, 0, 16'd1, 0, 0, 0, thr};
			send_triple(n, d);
			n[8] = thr - 16'd1;
			send_triple(n, d);
		end
		for (int i = 0; i < count; i++)
			send_random();
	endtask

	initial begin
		logic [15:0] n[9];
		logic [31:0] d[3];
		logic [15:0] thr_r;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		nrm = '{default: '0};
		ofs = '{default: '0};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero normals, axis planes, extremes, saturation
		n = '{default: '0};
		d = '{default: '0};
		send_triple(n, d);
		n = '{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF};
		d = '{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000};
		send_triple(n, d);
		d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
		send_triple(n, d);
		n = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000};
		send_triple(n, d);
		n = '{16'd1, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF};
		d = '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0001};
		send_triple(n, d);
		n = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h7FFF};
		d = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
		send_triple(n, d);
		n = '{16'h5A82, 16'h5A82, 0, 16'hA57E, 16'h5A82, 0, 0, 0, 16'h7FFF};
		d = '{32'h0003_0000, 32'hFFFD_8000, 32'h0000_4000};
		send_triple(n, d);

		run_phase(16'd1024, 230);
		set_min_det(16'd0);
		run_phase(16'd0, 230);
		set_min_det(16'hFFFF);
		run_phase(16'hFFFF, 230);
		thr_r = 16'($urandom_range(1, 32767));
		set_min_det(thr_r);
		run_phase(thr_r, 230);
		set_min_det(16'd1024);
		run_phase(16'd1024, 230);

		@(negedge clk);
		start = 1'b0;
		wait (points_pending == 0);
		repeat (LATENCY) @(posedge clk);
		if (failures == 0)
			$display("three_plane_intersection_unit regression: pass");
		else
			$display("three_plane_intersection_unit regression: fail");
		$finish;
	end

endmodule

// File: three_plane_intersection_unit.f
rtl/core/tpi_pkg.sv
rtl/core/tpi_cell.sv
rtl/core/tpi_front.sv
rtl/core/three_plane_intersection_unit.sv
tb/sv/tpi_checker.sv
tb/sv/tb_three_plane_intersection_unit.sv
